// ===== src/lrsi_pkg.sv =====
package lrsi_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned REG_W   = 32;

  localparam int unsigned ORIGIN_RESET = 399;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  localparam logic REG_ORIGIN_X = 1'b0;
  localparam logic REG_ORIGIN_Y = 1'b1;

endpackage

// ===== src/lrsi_req_if.sv =====
interface lrsi_req_if import lrsi_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (
    output valid, req_type, start_x, start_y, end_x, end_y,
    input  ready
  );

  modport sink (
    input  valid, req_type, start_x, start_y, end_x, end_y,
    output ready
  );
endinterface

// ===== src/lrsi_pix_if.sv =====
interface lrsi_pix_if import lrsi_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, last_pixel,
    output ready
  );
endinterface

// ===== src/lrsi_div.sv =====
module lrsi_div import lrsi_pkg::*; #(
  parameter int unsigned NUM_W = COORD_BITS_DEF + FRAC_BITS_DEF + 2,
  parameter int unsigned DEN_W = COORD_BITS_DEF + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [NUM_W-1:0] quo_q, quo_d;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    fits  = trial >= {1'b0, den_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      rem_d  = '0;
      den_d  = den_i;
      quo_d  = num_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      den_q  <= den_d;
      quo_q  <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

endmodule

// ===== src/line_rasterizer_slope_intercept_top.sv =====
// start request: setup, slope division, multiply, rounding and output from accept to pixel,
//   the bit-serial slope divider giving one quotient bit per cycle; a point line skips the divider
// next-pixel request: one multiply, one rounding and one output state
// one request in flight at a time; ready again the cycle the pixel is registered
// reset: async active low, no line active, origins 399, output empty
module line_rasterizer_slope_intercept_top import lrsi_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lrsi_req_if.sink           in_i,
  lrsi_pix_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]   pwdata,
  output logic [REG_W-1:0]   prdata,
  output logic               pready
);

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned F      = FRAC_BITS;
  localparam int unsigned NUM_W  = C + F + 2;
  localparam int unsigned DEN_W  = C + 1;
  localparam int unsigned SLP_W  = F + 2;
  localparam int unsigned PROD_W = F + C + 3;

  localparam logic signed [SLP_W-1:0] SLOPE_MAX = {2'b01, {F{1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_RND,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  logic                     line_active_q, line_active_d;
  logic                     steep_q, steep_d;
  logic signed [C-1:0]      major_current_q, major_current_d;
  logic signed [C-1:0]      major_start_q, major_start_d;
  logic signed [C-1:0]      major_final_q, major_final_d;
  logic [C-1:0]             minor_start_q, minor_start_d;
  logic signed [SLP_W-1:0]  slope_q, slope_d;
  logic                     slope_neg_q, slope_neg_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [C-1:0]             rnd_q, rnd_d;
  logic signed [C-1:0]      sx_q, sx_d, sy_q, sy_d, ex_q, ex_d, ey_q, ey_d;
  logic                     out_valid_q, out_valid_d;
  logic [C-1:0]             pix_x_q, pix_x_d, pix_y_q, pix_y_d;
  logic                     last_q, last_d;
  logic [C-1:0]             origin_x_q, origin_x_d, origin_y_q, origin_y_d;

  logic                     div_start;
  logic [NUM_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic                     div_done;
  logic [NUM_W-1:0]         div_quo;

  logic signed [C:0]        dx, dy, dmaj_s, dmin_s;
  logic [C:0]               adx, ady;
  logic                     steep_w, swap;
  logic [C-1:0]             dmaj, dmin_mag;
  logic signed [C-1:0]      a1, a2, b1, b2;
  logic [SLP_W-1:0]         slope_mag;
  logic [C-1:0]             off;
  logic signed [C:0]        off_s;
  logic                     prod_neg;
  logic [PROD_W-1:0]        mag, rsum;
  logic [C-1:0]             rnd_c;
  logic [C-1:0]             minor, x_c, y_c;
  logic                     at_final;
  logic                     out_load;
  logic                     in_fire;
  logic                     cfg_write;
  logic [PADDR_W-3:0]       reg_idx;

  lrsi_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // line setup from the latched endpoints
  always_comb begin
    dx       = {ex_q[C-1], ex_q} - {sx_q[C-1], sx_q};
    dy       = {ey_q[C-1], ey_q} - {sy_q[C-1], sy_q};
    adx      = dx[C] ? -dx : dx;
    ady      = dy[C] ? -dy : dy;
    steep_w  = ady > adx;
    dmaj_s   = steep_w ? dy : dx;
    dmin_s   = steep_w ? dx : dy;
    swap     = dmaj_s[C];
    dmaj     = steep_w ? ady[C-1:0] : adx[C-1:0];
    dmin_mag = steep_w ? adx[C-1:0] : ady[C-1:0];
    a1       = steep_w ? sy_q : sx_q;
    a2       = steep_w ? ey_q : ex_q;
    b1       = steep_w ? sx_q : sy_q;
    b2       = steep_w ? ex_q : ey_q;
    div_num  = {1'b0, dmin_mag, {F{1'b0}}, 1'b0} + NUM_W'(dmaj);
    div_den  = {dmaj, 1'b0};
  end

  // pixel datapath
  always_comb begin
    slope_mag = {1'b0, div_quo[F:0]};
    off       = major_current_q - major_start_q;
    off_s     = $signed({1'b0, off});
    prod_neg  = prod_q[PROD_W-1];
    mag       = prod_neg ? -prod_q : prod_q;
    rsum      = mag + (PROD_W'(1) << (F - 1));
    rnd_c     = rsum[F+C-1:F];
    minor     = minor_start_q + rnd_q;
    x_c       = steep_q ? minor : major_current_q;
    y_c       = steep_q ? major_current_q : minor;
    at_final  = major_current_q >= major_final_q;
  end

  assign in_fire   = in_i.valid && in_i.ready;
  assign out_load  = !out_valid_q || out_o.ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[PADDR_W-1:2];

  always_comb begin
    state_d         = state_q;
    line_active_d   = line_active_q;
    steep_d         = steep_q;
    major_current_d = major_current_q;
    major_start_d   = major_start_q;
    major_final_d   = major_final_q;
    minor_start_d   = minor_start_q;
    slope_d         = slope_q;
    slope_neg_d     = slope_neg_q;
    prod_d          = prod_q;
    rnd_d           = rnd_q;
    sx_d            = sx_q;
    sy_d            = sy_q;
    ex_d            = ex_q;
    ey_d            = ey_q;
    out_valid_d     = out_valid_q && !out_o.ready;
    pix_x_d         = pix_x_q;
    pix_y_d         = pix_y_q;
    last_d          = last_q;
    origin_x_d      = origin_x_q;
    origin_y_d      = origin_y_q;
    div_start       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.req_type == REQ_START) begin
            sx_d    = in_i.start_x;
            sy_d    = in_i.start_y;
            ex_d    = in_i.end_x;
            ey_d    = in_i.end_y;
            state_d = ST_PREP;
          end else if (line_active_q) begin
            major_current_d = major_current_q + C'(1);
            state_d         = ST_MUL;
          end
        end
      end
      ST_PREP: begin
        steep_d         = steep_w;
        major_start_d   = swap ? a2 : a1;
        major_current_d = swap ? a2 : a1;
        major_final_d   = swap ? a1 : a2;
        minor_start_d   = swap ? b2 : b1;
        slope_neg_d     = dmin_s[C] ^ swap;
        if (dmaj == '0) begin
          slope_d = '0;
          state_d = ST_MUL;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          slope_d = slope_neg_q ? -$signed(slope_mag) : $signed(slope_mag);
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = slope_q * off_s;
        state_d = ST_RND;
      end
      ST_RND: begin
        rnd_d   = prod_neg ? -rnd_c : rnd_c;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_d   = 1'b1;
          pix_x_d       = x_c + origin_x_q;
          pix_y_d       = y_c + origin_y_q;
          last_d        = at_final;
          line_active_d = !at_final;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_write) begin
      case (reg_idx)
        REG_ORIGIN_X: origin_x_d = pwdata[C-1:0];
        REG_ORIGIN_Y: origin_y_d = pwdata[C-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      line_active_q   <= 1'b0;
      steep_q         <= 1'b0;
      major_current_q <= '0;
      major_start_q   <= '0;
      major_final_q   <= '0;
      minor_start_q   <= '0;
      slope_q         <= '0;
      slope_neg_q     <= 1'b0;
      prod_q          <= '0;
      rnd_q           <= '0;
      sx_q            <= '0;
      sy_q            <= '0;
      ex_q            <= '0;
      ey_q            <= '0;
      out_valid_q     <= 1'b0;
      pix_x_q         <= '0;
      pix_y_q         <= '0;
      last_q          <= 1'b0;
      origin_x_q      <= C'(ORIGIN_RESET);
      origin_y_q      <= C'(ORIGIN_RESET);
    end else begin
      state_q         <= state_d;
      line_active_q   <= line_active_d;
      steep_q         <= steep_d;
      major_current_q <= major_current_d;
      major_start_q   <= major_start_d;
      major_final_q   <= major_final_d;
      minor_start_q   <= minor_start_d;
      slope_q         <= slope_d;
      slope_neg_q     <= slope_neg_d;
      prod_q          <= prod_d;
      rnd_q           <= rnd_d;
      sx_q            <= sx_d;
      sy_q            <= sy_d;
      ex_q            <= ex_d;
      ey_q            <= ey_d;
      out_valid_q     <= out_valid_d;
      pix_x_q         <= pix_x_d;
      pix_y_q         <= pix_y_d;
      last_q          <= last_d;
      origin_x_q      <= origin_x_d;
      origin_y_q      <= origin_y_d;
    end
  end

  assign in_i.ready       = state_q == ST_IDLE;
  assign out_o.valid      = out_valid_q;
  assign out_o.pixel_x    = pix_x_q;
  assign out_o.pixel_y    = pix_y_q;
  assign out_o.last_pixel = last_q;

  assign pready = 1'b1;
  assign prdata = (reg_idx == REG_ORIGIN_Y) ? REG_W'(origin_y_q) : REG_W'(origin_x_q);

  a_start_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.req_type == REQ_START) |=> state_q == ST_PREP)
    else $error("start request did not enter setup");

  a_slope_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> (slope_q <= SLOPE_MAX && slope_q >= -SLOPE_MAX))
    else $error("slope out of range");

  a_active_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_active_q |-> major_current_q <= major_final_q)
    else $error("major coordinate past line end");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !out_valid_q) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("pixel not registered with free output");

endmodule
